>>> hw/rtl/ipfd_pkg.sv
`timescale 1ns / 1ps
package ipfd_pkg;

  // Default sizes of the slot pool and of the pending store.
  localparam int POOL_SIZE_DEF = 1024;
  localparam int PEND_CAP_DEF  = 1024;

  // Fixed field widths.
  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int FENCE_W  = 64;
  localparam int PREFIX_W = 11;

  // Request modes.
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_DEFER   = 2'd2;
  localparam logic [1:0] MODE_COLLECT = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

endpackage

>>> hw/rtl/index_pool_fence_deferred_free.sv
`timescale 1ns / 1ps
// Allocate and free pass through decode to the result register; a single-slot pop adds a read of
// the free stack. A deferred free walks down the pending entries with a later fence, shifting each
// up by one, and a collect moves due entries from the head onto the free stack until the pending
// store is empty, an entry stays pending or the free stack is full. One item is in flight at a
// time, and a stalled result holds off the next item. Reset (synchronous, active high) empties
// both stores and clears prefix and bump pointer; memories are not cleared.
module index_pool_fence_deferred_free #(
  parameter int POOL_SIZE        = ipfd_pkg::POOL_SIZE_DEF,
  parameter int PENDING_CAPACITY = ipfd_pkg::PEND_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [10:0] count,
  input  logic [9:0]  slot_index,
  input  logic        index_is_invalid,
  input  logic [63:0] fence,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  granted_index,
  output logic [1:0]  status,
  output logic [10:0] moved_count
);

  localparam int FD_W = $clog2(POOL_SIZE + 1);
  localparam int FA_W = $clog2(POOL_SIZE);
  localparam int PD_W = $clog2(PENDING_CAPACITY + 1);
  localparam int PA_W = $clog2(PENDING_CAPACITY);
  localparam int BW   = $clog2(POOL_SIZE + 2048) + 1;
  localparam int PE_W = ipfd_pkg::FENCE_W + ipfd_pkg::SLOT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_POPR = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_INSW = 3'd4;
  localparam logic [2:0] S_COL  = 3'd5;
  localparam logic [2:0] S_COLW = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                    state;
  logic [ipfd_pkg::PREFIX_W-1:0] reserved_prefix;
  logic [BW-1:0]                 bump;
  logic [FD_W-1:0]               fdepth;
  logic [PD_W-1:0]               pdepth;
  logic [PA_W-1:0]               head;
  logic [PD_W-1:0]               pos;
  logic [PD_W-1:0]               moved;

  // Latched request fields.
  logic [1:0]                    mode_r;
  logic [ipfd_pkg::COUNT_W-1:0]  count_r;
  logic [ipfd_pkg::SLOT_W-1:0]   slot_r;
  logic                          inv_r;
  logic [ipfd_pkg::FENCE_W-1:0]  fence_r;

  // Result being built.
  logic [ipfd_pkg::SLOT_W-1:0]   res_granted;
  logic [1:0]                    res_status;

  // Free stack memory.
  logic [ipfd_pkg::SLOT_W-1:0] fs_mem [POOL_SIZE];
  logic                        fs_we;
  logic [FA_W-1:0]             fs_waddr;
  logic [FA_W-1:0]             fs_raddr;
  logic [ipfd_pkg::SLOT_W-1:0] fs_wdata;
  logic [ipfd_pkg::SLOT_W-1:0] fs_rdata;

  // Pending memory, kept as a sorted ring starting at head.
  logic [PE_W-1:0] pe_mem [PENDING_CAPACITY];
  logic            pe_we;
  logic [PA_W-1:0] pe_waddr;
  logic [PA_W-1:0] pe_raddr;
  logic [PE_W-1:0] pe_wdata;
  logic [PE_W-1:0] pe_rdata;

  logic [ipfd_pkg::FENCE_W-1:0] rd_fence;
  logic [ipfd_pkg::SLOT_W-1:0]  rd_slot;
  logic [FD_W-1:0]              fdepth_m1;
  logic [PD_W-1:0]              pos_m1;
  logic [BW-1:0]                bump_sum;
  logic                         fs_full;
  logic                         cfg_wr;

  // Map a position in sorted order to a memory address.
  function automatic logic [PA_W-1:0] phys(input logic [PA_W-1:0] h, input logic [PD_W-1:0] l);
    logic [PD_W:0] sum;
    sum = (PD_W + 1)'(h) + (PD_W + 1)'(l);
    if (sum >= (PD_W + 1)'(PENDING_CAPACITY)) begin
      sum = sum - (PD_W + 1)'(PENDING_CAPACITY);
    end
    return sum[PA_W-1:0];
  endfunction

  assign rd_fence  = pe_rdata[PE_W-1:ipfd_pkg::SLOT_W];
  assign rd_slot   = pe_rdata[ipfd_pkg::SLOT_W-1:0];
  assign fdepth_m1 = fdepth - FD_W'(1);
  assign pos_m1    = pos - PD_W'(1);
  assign bump_sum  = bump + BW'(count_r);
  assign fs_full   = (fdepth >= FD_W'(POOL_SIZE));
  assign in_stall  = (state != S_IDLE);
  assign pready    = 1'b1;
  assign prdata    = 32'(reserved_prefix);
  assign cfg_wr    = psel && penable && pwrite && !paddr[2];

  // Memory port control.
  always_comb begin
    fs_we    = 1'b0;
    fs_waddr = fdepth[FA_W-1:0];
    fs_wdata = slot_r;
    fs_raddr = fdepth_m1[FA_W-1:0];
    pe_we    = 1'b0;
    pe_waddr = phys(head, pos);
    pe_wdata = {fence_r, slot_r};
    pe_raddr = phys(head, pos_m1);
    unique case (state)
      S_DEC: begin
        if (mode_r == ipfd_pkg::MODE_FREE && !inv_r && !fs_full) begin
          fs_we = 1'b1;
        end
      end
      S_INS: begin
        if (pos == '0) begin
          pe_we = 1'b1;
        end
      end
      S_INSW: begin
        pe_we = 1'b1;
        if (rd_fence > fence_r) begin
          pe_wdata = pe_rdata;
        end
      end
      S_COL: begin
        pe_raddr = head;
      end
      S_COLW: begin
        fs_wdata = rd_slot;
        if (rd_fence <= fence_r && !fs_full) begin
          fs_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Free stack storage.
  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    fs_rdata <= fs_mem[fs_raddr];
  end

  // Pending storage.
  always_ff @(posedge clk) begin
    if (pe_we) begin
      pe_mem[pe_waddr] <= pe_wdata;
    end
    pe_rdata <= pe_mem[pe_raddr];
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_r  <= mode;
      count_r <= count;
      slot_r  <= slot_index;
      inv_r   <= index_is_invalid;
      fence_r <= fence;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      reserved_prefix <= '0;
      bump            <= '0;
      fdepth          <= '0;
      pdepth          <= '0;
      head            <= '0;
      pos             <= '0;
      moved           <= '0;
      out_valid       <= 1'b0;
      res_granted     <= '0;
      res_status      <= ipfd_pkg::ST_OK;
    end else begin
      if (cfg_wr) begin
        reserved_prefix <= pwdata[ipfd_pkg::PREFIX_W-1:0];
        bump            <= BW'(pwdata[ipfd_pkg::PREFIX_W-1:0]);
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          res_granted <= '0;
          res_status  <= ipfd_pkg::ST_OK;
          moved       <= '0;
          state       <= S_DONE;
          unique case (mode_r)
            ipfd_pkg::MODE_ALLOC: begin
              if (count_r == 11'd1 && fdepth != '0) begin
                state <= S_POPR;
              end else if (count_r == '0 || bump_sum > BW'(POOL_SIZE)) begin
                res_status <= ipfd_pkg::ST_FULL;
              end else begin
                res_granted <= bump[ipfd_pkg::SLOT_W-1:0];
                bump        <= bump_sum;
              end
            end
            ipfd_pkg::MODE_FREE: begin
              if (inv_r) begin
                res_status <= ipfd_pkg::ST_INVALID;
              end else if (fs_full) begin
                res_status <= ipfd_pkg::ST_OVERFLOW;
              end else begin
                fdepth <= fdepth + FD_W'(1);
              end
            end
            ipfd_pkg::MODE_DEFER: begin
              if (inv_r) begin
                res_status <= ipfd_pkg::ST_INVALID;
              end else if (pdepth >= PD_W'(PENDING_CAPACITY)) begin
                res_status <= ipfd_pkg::ST_OVERFLOW;
              end else begin
                pos   <= pdepth;
                state <= S_INS;
              end
            end
            ipfd_pkg::MODE_COLLECT: begin
              state <= S_COL;
            end
            default: begin
            end
          endcase
        end
        S_POPR: begin
          res_granted <= fs_rdata;
          fdepth      <= fdepth_m1;
          state       <= S_DONE;
        end
        // Walk down from the tail, shifting later fences up by one.
        S_INS: begin
          if (pos == '0) begin
            pdepth <= pdepth + PD_W'(1);
            state  <= S_DONE;
          end else begin
            state <= S_INSW;
          end
        end
        S_INSW: begin
          if (rd_fence > fence_r) begin
            pos   <= pos_m1;
            state <= S_INS;
          end else begin
            pdepth <= pdepth + PD_W'(1);
            state  <= S_DONE;
          end
        end
        // Pop due entries from the head onto the free stack.
        S_COL: begin
          state <= (pdepth == '0) ? S_DONE : S_COLW;
        end
        S_COLW: begin
          state <= S_DONE;
          if (rd_fence <= fence_r) begin
            if (fs_full) begin
              res_status <= ipfd_pkg::ST_OVERFLOW;
            end else begin
              fdepth <= fdepth + FD_W'(1);
              head   <= (head == PA_W'(PENDING_CAPACITY - 1)) ? '0 : head + PA_W'(1);
              pdepth <= pdepth - PD_W'(1);
              moved  <= moved + PD_W'(1);
              state  <= S_COL;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            granted_index <= res_granted;
            status        <= res_status;
            moved_count   <= 11'(moved);
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on internal consistency.
  a_fdepth_bound: assert property (@(posedge clk) disable iff (rst)
    fdepth <= FD_W'(POOL_SIZE)) else $error("free stack depth beyond pool");

  a_pdepth_bound: assert property (@(posedge clk) disable iff (rst)
    pdepth <= PD_W'(PENDING_CAPACITY)) else $error("pending depth beyond capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DEC)) else $error("accepted item not decoded");

  a_done_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !(out_valid && out_stall)) |=> out_valid)
    else $error("result not presented");

endmodule
